// ===== rtl/core/pmr_pkg.sv =====
// ----------------------------------------------------------------------------
// pmr_pkg
// Shared types and constants of the polygon mask rasterizer.
// ----------------------------------------------------------------------------
package pmr_pkg;

    localparam int GRID_SIDE_DEF    = 32;
    localparam int MAX_VERTICES_DEF = 64;

    localparam int COORD_W = 32;
    localparam int MASK_W  = 32;
    localparam int ROW_W   = 5;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_CLEAR     = 2'd0;
    localparam t_opcode OP_APPEND    = 2'd1;
    localparam t_opcode OP_TEST      = 2'd2;
    localparam t_opcode OP_RASTERIZE = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Request to the edge walker: test one point against the stored ring.
    typedef struct packed {
        logic   start;
        t_coord px;
        t_coord py;
    } t_walk_req;

    typedef struct packed {
        logic done;
        logic in_poly;
    } t_walk_rsp;

endpackage

// ===== rtl/core/pmr_if.sv =====
// ----------------------------------------------------------------------------
// pmr_if
// Valid/ready channels of the polygon mask rasterizer.
// ----------------------------------------------------------------------------
interface pmr_in_if;
    import pmr_pkg::*;

    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_coord  value_x;
    t_coord  value_y;

    modport source (output valid, output opcode, output value_x, output value_y,
                    input ready);
    modport sink   (input valid, input opcode, input value_x, input value_y,
                    output ready);
endinterface

interface pmr_out_if;
    import pmr_pkg::*;

    logic              valid;
    logic              ready;
    logic              inside_res;
    logic [ROW_W-1:0]  row_index;
    logic [MASK_W-1:0] row_mask;
    logic              last;
    logic              vertex_overflow;

    modport source (output valid, output inside_res, output row_index, output row_mask,
                    output last, output vertex_overflow, input ready);
    modport sink   (input valid, input inside_res, input row_index, input row_mask,
                    input last, input vertex_overflow, output ready);
endinterface

// ===== rtl/core/polygon_mask_rasterizer.sv =====
// ----------------------------------------------------------------------------
// polygon_mask_rasterizer
// Even-odd point-in-polygon test and square mask rasterizer over a stored ring.
// ----------------------------------------------------------------------------
// Usage: items arrive on i_in (opcode, value_x, value_y). Clear and append
// produce no beat. Appends beyond MAX_VERTICES are dropped and set the
// sticky overflow flag. A test gives one beat with its result in inside_res
// and last set. A rasterize item gives min(GRID_SIDE,32) beats, one row mask
// each, last on the final row.
// Timing: the ring walk streams one vertex per cycle from the vertex memory.
// A rasterize item first sets up its centres (one reciprocal division per axis).
// The result sits in an output register: a stalled receiver does not block
// accepting the next item, but a new beat waits until the register frees.
// Reset empties the ring and clears the overflow flag; the vertex memory is
// not cleared, and only entries written since the last clear are read.
// ----------------------------------------------------------------------------
module polygon_mask_rasterizer #(
    parameter int GRID_SIDE    = pmr_pkg::GRID_SIDE_DEF,
    parameter int MAX_VERTICES = pmr_pkg::MAX_VERTICES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pmr_in_if.sink   i_in,
    pmr_out_if.source o_out
);
    import pmr_pkg::*;

    localparam int AW      = $clog2(MAX_VERTICES);
    localparam int CW      = $clog2(MAX_VERTICES + 1);
    localparam int DIVISOR = 2 * GRID_SIDE;
    localparam int DW      = $clog2(DIVISOR);
    localparam int ROWS    = (GRID_SIDE < 32) ? GRID_SIDE : 32;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PT   = 3'd2;
    localparam logic [2:0] ST_PW   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]    r_state;
    logic          r_raster;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          in_fire;
    logic          wr_en;

    t_coord     r_px, r_py;
    t_walk_req  walk_req;
    t_walk_rsp  walk_rsp;

    // Centre generators: magnitude q with remainder r, stepped by q2/r2.
    logic          r_sx, r_sy;
    logic [31:0]   r_q0x, r_q2x, r_qx, r_q2y, r_qy;
    logic [DW-1:0] r_r0x, r_r2x, r_rx, r_r2y, r_ry;
    logic [DW:0]   sum_rx, sum_ry;
    logic          wrap_x, wrap_y;
    logic [31:0]   n_qx, n_qy;
    logic [DW-1:0] n_rx, n_ry;

    logic          div_done_x, div_done_y;
    logic [31:0]   div_qx, div_qy;
    logic [DW-1:0] div_rx, div_ry;
    logic [DW:0]   two_rx, two_ry;
    logic          ge_x, ge_y;

    logic [ROW_W-1:0]  r_row, r_col;
    logic [MASK_W-1:0] r_mask;
    logic              r_res;

    logic              r_ovalid;
    logic              r_oinside;
    logic [ROW_W-1:0]  r_orow;
    logic [MASK_W-1:0] r_omask;
    logic              r_olast;
    logic              r_oovf;
    logic              out_free;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid & i_in.ready;
    assign out_free   = ~r_ovalid | o_out.ready;
    assign wr_en      = in_fire && (i_in.opcode == OP_APPEND)
                        && (r_count < CW'(MAX_VERTICES));

    pmr_div #(.DIVISOR(DIVISOR)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire && (i_in.opcode == OP_RASTERIZE)),
        .i_dividend (i_in.value_x[31] ? 32'(-i_in.value_x) : 32'(i_in.value_x)),
        .o_done     (div_done_x),
        .o_quot     (div_qx),
        .o_rem      (div_rx)
    );

    pmr_div #(.DIVISOR(DIVISOR)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire && (i_in.opcode == OP_RASTERIZE)),
        .i_dividend (i_in.value_y[31] ? 32'(-i_in.value_y) : 32'(i_in.value_y)),
        .o_done     (div_done_y),
        .o_quot     (div_qy),
        .o_rem      (div_ry)
    );

    assign walk_req.start = (r_state == ST_PT);
    assign walk_req.px    = r_px;
    assign walk_req.py    = r_py;

    pmr_edge_walk #(.MAX_VERTICES(MAX_VERTICES)) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_x    (i_in.value_x),
        .i_wr_y    (i_in.value_y),
        .i_count   (r_count),
        .i_req     (walk_req),
        .o_rsp     (walk_rsp)
    );

    // Doubling the first quotient gives the step between neighboring centres.
    assign two_rx = {div_rx, 1'b0};
    assign two_ry = {div_ry, 1'b0};
    assign ge_x   = two_rx >= (DW+1)'(DIVISOR);
    assign ge_y   = two_ry >= (DW+1)'(DIVISOR);

    assign sum_rx = (DW+1)'(r_rx) + (DW+1)'(r_r2x);
    assign sum_ry = (DW+1)'(r_ry) + (DW+1)'(r_r2y);
    assign wrap_x = sum_rx >= (DW+1)'(DIVISOR);
    assign wrap_y = sum_ry >= (DW+1)'(DIVISOR);
    assign n_qx   = r_qx + r_q2x + 32'(wrap_x);
    assign n_qy   = r_qy + r_q2y + 32'(wrap_y);
    assign n_rx   = wrap_x ? DW'(sum_rx - (DW+1)'(DIVISOR)) : DW'(sum_rx);
    assign n_ry   = wrap_y ? DW'(sum_ry - (DW+1)'(DIVISOR)) : DW'(sum_ry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        unique case (i_in.opcode)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_ovf   <= 1'b0;
                            end
                            OP_APPEND: begin
                                if (r_count < CW'(MAX_VERTICES)) begin
                                    r_count <= r_count + CW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            OP_TEST: begin
                                r_raster <= 1'b0;
                                r_px     <= i_in.value_x;
                                r_py     <= i_in.value_y;
                                r_state  <= ST_PT;
                            end
                            OP_RASTERIZE: begin
                                r_raster <= 1'b1;
                                r_sx     <= i_in.value_x[31];
                                r_sy     <= i_in.value_y[31];
                                r_state  <= ST_DIV;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_done_x && div_done_y) begin
                        r_q0x  <= div_qx;
                        r_r0x  <= div_rx;
                        r_qx   <= div_qx;
                        r_rx   <= div_rx;
                        r_qy   <= div_qy;
                        r_ry   <= div_ry;
                        r_q2x  <= {div_qx[30:0], 1'b0} + 32'(ge_x);
                        r_r2x  <= ge_x ? DW'(two_rx - (DW+1)'(DIVISOR)) : DW'(two_rx);
                        r_q2y  <= {div_qy[30:0], 1'b0} + 32'(ge_y);
                        r_r2y  <= ge_y ? DW'(two_ry - (DW+1)'(DIVISOR)) : DW'(two_ry);
                        r_px   <= r_sx ? t_coord'(-div_qx) : t_coord'(div_qx);
                        r_py   <= r_sy ? t_coord'(-div_qy) : t_coord'(div_qy);
                        r_row  <= '0;
                        r_col  <= '0;
                        r_mask <= '0;
                        r_state <= ST_PT;
                    end
                end
                ST_PT: begin
                    r_state <= ST_PW;
                end
                ST_PW: begin
                    if (walk_rsp.done) begin
                        if (!r_raster) begin
                            r_res   <= walk_rsp.in_poly;
                            r_state <= ST_OUT;
                        end else begin
                            r_mask[r_col] <= walk_rsp.in_poly;
                            if (r_col == ROW_W'(ROWS - 1)) begin
                                r_state <= ST_OUT;
                            end else begin
                                r_col   <= r_col + ROW_W'(1);
                                r_qx    <= n_qx;
                                r_rx    <= n_rx;
                                r_px    <= r_sx ? t_coord'(-n_qx) : t_coord'(n_qx);
                                r_state <= ST_PT;
                            end
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_oovf    <= r_ovf;
                        if (!r_raster) begin
                            r_oinside <= r_res;
                            r_orow    <= '0;
                            r_omask   <= '0;
                            r_olast   <= 1'b1;
                            r_state   <= ST_IDLE;
                        end else begin
                            r_oinside <= 1'b0;
                            r_orow    <= r_row;
                            r_omask   <= r_mask;
                            r_olast   <= (r_row == ROW_W'(ROWS - 1));
                            if (r_row == ROW_W'(ROWS - 1)) begin
                                r_state <= ST_IDLE;
                            end else begin
                                r_row   <= r_row + ROW_W'(1);
                                r_col   <= '0;
                                r_mask  <= '0;
                                r_qx    <= r_q0x;
                                r_rx    <= r_r0x;
                                r_px    <= r_sx ? t_coord'(-r_q0x) : t_coord'(r_q0x);
                                r_qy    <= n_qy;
                                r_ry    <= n_ry;
                                r_py    <= r_sy ? t_coord'(-n_qy) : t_coord'(n_qy);
                                r_state <= ST_PT;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.inside_res      = r_oinside;
    assign o_out.row_index       = r_orow;
    assign o_out.row_mask        = r_omask;
    assign o_out.last            = r_olast;
    assign o_out.vertex_overflow = r_oovf;

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CW'(MAX_VERTICES)))
        else $error("overflow flag set while the ring has room");

    a_walk_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_rsp.done |-> (r_state == ST_PW))
        else $error("ring walk finished outside the wait state");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> r_ovalid)
        else $error("result beat not loaded into the output register");

endmodule

// ===== rtl/core/pmr_div.sv =====
// ----------------------------------------------------------------------------
// pmr_div
// Division of a 32-bit magnitude by a constant through a reciprocal multiply.
// Products, quotient and remainder are registered in turn; o_done marks them.
// ----------------------------------------------------------------------------
module pmr_div #(
    parameter int DIVISOR = 2 * pmr_pkg::GRID_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [31:0]                  i_dividend,
    output logic                         o_done,
    output logic [31:0]                  o_quot,
    output logic [$clog2(DIVISOR)-1:0]   o_rem
);
    localparam int DW = $clog2(DIVISOR);
    localparam int SH = 32 + DW;
    // Rounded-up reciprocal; with this shift the product gives the exact
    // floor quotient for every 32-bit dividend.
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [15:0]   RECIP_LO = RECIP[15:0];
    localparam logic [16:0]   RECIP_HI = RECIP[32:16];
    localparam logic [DW-1:0] DIV_LO   = DW'(DIVISOR);

    logic          r_v1, r_v2, r_v3, r_v4;
    logic          r_done;
    logic [31:0]   r_n;
    logic [47:0]   r_plo;
    logic [48:0]   r_phi;
    logic [64:0]   r_prod;
    logic [31:0]   r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] qd_lo;

    // The remainder is below the divisor, so its low bits are enough.
    assign qd_lo = r_q[DW-1:0] * DIV_LO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_done <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_dividend;
        end
        if (r_v1) begin
            r_plo <= r_n * RECIP_LO;
            r_phi <= r_n * RECIP_HI;
        end
        if (r_v2) begin
            r_prod <= {r_phi, 16'd0} + 65'(r_plo);
        end
        if (r_v3) begin
            r_q <= 32'(r_prod >> SH);
        end
        if (r_v4) begin
            r_rem <= r_n[DW-1:0] - qd_lo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    a_done_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |=> r_done)
        else $error("division result not flagged");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ((DW+1)'(r_rem) < (DW+1)'(DIVISOR)))
        else $error("division remainder out of range");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !(r_v1 || r_v2 || r_v3 || r_v4))
        else $error("division started while one is running");

endmodule

// ===== rtl/core/pmr_edge_walk.sv =====
// ----------------------------------------------------------------------------
// pmr_edge_walk
// Vertex memory and the edge pipeline that classifies one point per request.
// ----------------------------------------------------------------------------
module pmr_edge_walk #(
    parameter int MAX_VERTICES = pmr_pkg::MAX_VERTICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0]     i_wr_addr,
    input  pmr_pkg::t_coord                     i_wr_x,
    input  pmr_pkg::t_coord                     i_wr_y,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]   i_count,
    input  pmr_pkg::t_walk_req                  i_req,
    output pmr_pkg::t_walk_rsp                  o_rsp
);
    import pmr_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [2*COORD_W-1:0] r_mem [MAX_VERTICES];
    logic [2*COORD_W-1:0] r_rd;

    logic          r_busy;
    logic          r_issue;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_n;
    t_coord        r_px;
    t_coord        r_py;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] k_prev;

    // Stage 0: read data; stage 1: differences; stage 2: products.
    logic r_v0, r_f0, r_l0;
    logic r_v1, r_l1;
    logic r_v2, r_l2;
    t_coord r_ax, r_ay;
    t_coord cur_x, cur_y;

    logic signed [COORD_W:0] r_dx, r_dy, r_ex, r_ey;
    logic r_box1, r_str1, r_dyp1;
    logic signed [2*COORD_W+1:0] r_p1, r_p2;
    logic r_box2, r_str2, r_dyp2;

    logic r_onedge, r_par;
    logic n_onedge, n_par;
    logic r_done, r_inside;

    t_coord lox, hix, loy, hiy;
    logic   crosses;

    assign k_prev  = r_k - CW'(1);
    assign rd_addr = (r_k == '0) ? AW'(r_n - CW'(1)) : AW'(k_prev);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
        if (r_issue) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign cur_x = r_rd[2*COORD_W-1:COORD_W];
    assign cur_y = r_rd[COORD_W-1:0];
    assign lox   = (r_ax < cur_x) ? r_ax : cur_x;
    assign hix   = (r_ax < cur_x) ? cur_x : r_ax;
    assign loy   = (r_ay < cur_y) ? r_ay : cur_y;
    assign hiy   = (r_ay < cur_y) ? cur_y : r_ay;

    // The on-edge test and the crossing test share the two products.
    assign crosses  = r_dyp2 ? (r_p2 < r_p1) : (r_p2 > r_p1);
    assign n_onedge = r_onedge | (r_box2 & (r_p1 == r_p2));
    assign n_par    = r_par ^ (r_str2 & crosses);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_issue <= 1'b0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_px     <= i_req.px;
                r_py     <= i_req.py;
                r_n      <= i_count;
                r_k      <= '0;
                r_onedge <= 1'b0;
                r_par    <= 1'b0;
                if (i_count == '0) begin
                    r_done   <= 1'b1;
                    r_inside <= 1'b0;
                end else begin
                    r_busy  <= 1'b1;
                    r_issue <= 1'b1;
                end
            end else begin
                if (r_issue) begin
                    r_k <= r_k + CW'(1);
                    if (r_k == r_n) begin
                        r_issue <= 1'b0;
                    end
                end
                if (r_v2) begin
                    r_onedge <= n_onedge;
                    r_par    <= n_par;
                    if (r_l2) begin
                        r_busy   <= 1'b0;
                        r_done   <= 1'b1;
                        r_inside <= n_onedge | n_par;
                    end
                end
            end
            r_v0 <= r_issue;
            r_f0 <= (r_k == '0);
            r_l0 <= (r_k == r_n);
            r_v1 <= r_v0 & ~r_f0;
            r_l1 <= r_l0;
            r_v2 <= r_v1;
            r_l2 <= r_l1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v0) begin
            r_ax   <= cur_x;
            r_ay   <= cur_y;
            r_dx   <= (COORD_W+1)'(cur_x) - (COORD_W+1)'(r_ax);
            r_dy   <= (COORD_W+1)'(cur_y) - (COORD_W+1)'(r_ay);
            r_ex   <= (COORD_W+1)'(r_px) - (COORD_W+1)'(r_ax);
            r_ey   <= (COORD_W+1)'(r_py) - (COORD_W+1)'(r_ay);
            r_box1 <= (r_px >= lox) && (r_px <= hix) && (r_py >= loy) && (r_py <= hiy);
            r_str1 <= (r_ay > r_py) != (cur_y > r_py);
            r_dyp1 <= cur_y > r_ay;
        end
        r_p1   <= r_dx * r_ey;
        r_p2   <= r_dy * r_ex;
        r_box2 <= r_box1;
        r_str2 <= r_str1;
        r_dyp2 <= r_dyp1;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.in_poly = r_inside;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("point request while the ring walk is running");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !r_busy)
        else $error("vertex write during a ring walk");

endmodule

// ===== sim/tb_polygon_mask_rasterizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_mask_rasterizer
// Drives clear, append, point test and rasterize items into the polygon mask
// rasterizer and checks every output beat against a behavioral ring model.
// The model does the even-odd crossing test exactly in wide integer arithmetic.
// ----------------------------------------------------------------------------
module tb_polygon_mask_rasterizer;
    import pmr_pkg::*;

    localparam int RING_DEPTH   = MAX_VERTICES_DEF;
    localparam int MASK_ROWS    = (GRID_SIDE_DEF < 32) ? GRID_SIDE_DEF : 32;
    localparam int STALL_LIMIT  = 40000;

    typedef struct {
        bit          in_poly;
        bit [4:0]    row;
        bit [31:0]   mask;
        bit          last;
        bit          ovf;
    } t_row_beat;

    logic i_clk;
    logic i_rst_n;

    pmr_in_if  in_ch ();
    pmr_out_if out_ch ();

    polygon_mask_rasterizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Model state of the stored ring.
    longint    ring_x [RING_DEPTH];
    longint    ring_y [RING_DEPTH];
    int        ring_len;
    bit        ring_ovf;
    t_row_beat pending_beats [$];

    int  err_count = 0;
    int  item_count;
    bit  calm;
    int  idle_cycles = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Sign of a*b - c*d, exact.
    function automatic int product_sign(longint a, longint b, longint c, longint d);
        logic signed [79:0] a80, b80, c80, d80, diff;
        a80 = a;
        b80 = b;
        c80 = c;
        d80 = d;
        diff = a80 * b80 - c80 * d80;
        if (diff == 0)
            return 0;
        return (diff < 0) ? -1 : 1;
    endfunction

    function automatic bit point_in_ring(longint px, longint py);
        bit     odd;
        int     prev;
        longint ax, ay, bx, by, dx, dy, ex, ey;
        int     c;
        odd = 1'b0;
        if (ring_len == 0)
            return 1'b0;
        prev = ring_len - 1;
        for (int i = 0; i < ring_len; i++) begin
            ax = ring_x[prev];
            ay = ring_y[prev];
            bx = ring_x[i];
            by = ring_y[i];
            dx = bx - ax;
            dy = by - ay;
            ex = px - ax;
            ey = py - ay;
            if (product_sign(dx, ey, dy, ex) == 0 &&
                px >= ((ax < bx) ? ax : bx) && px <= ((ax < bx) ? bx : ax) &&
                py >= ((ay < by) ? ay : by) && py <= ((ay < by) ? by : ay))
                return 1'b1;
            if ((ay > py) != (by > py)) begin
                c = product_sign(ex, dy, dx, ey);
                if ((dy > 0) ? (c < 0) : (c > 0))
                    odd = !odd;
            end
            prev = i;
        end
        return odd;
    endfunction

    function automatic longint centre_of(int idx, longint extent);
        return (2 * longint'(idx) + 1) * extent / (2 * longint'(GRID_SIDE_DEF));
    endfunction

    // Updates the ring model for one accepted item and queues its beats.
    task automatic predict_beats(t_opcode op, t_coord x, t_coord y);
        t_row_beat b;
        bit [31:0] m;
        longint    cy;
        case (op)
            OP_CLEAR: begin
                ring_len = 0;
                ring_ovf = 1'b0;
            end
            OP_APPEND: begin
                if (ring_len < RING_DEPTH) begin
                    ring_x[ring_len] = x;
                    ring_y[ring_len] = y;
                    ring_len++;
                end else begin
                    ring_ovf = 1'b1;
                end
            end
            OP_TEST: begin
                b.in_poly = point_in_ring(x, y);
                b.row = 0;
                b.mask = 0;
                b.last = 1'b1;
                b.ovf = ring_ovf;
                pending_beats = {pending_beats, b};
            end
            default: begin
                for (int r = 0; r < MASK_ROWS; r++) begin
                    cy = centre_of(r, y);
                    m = 0;
                    for (int c = 0; c < MASK_ROWS; c++)
                        if (point_in_ring(centre_of(c, x), cy))
                            m[c] = 1'b1;
                    b.in_poly = 1'b0;
                    b.row = r[4:0];
                    b.mask = m;
                    b.last = (r == MASK_ROWS - 1);
                    b.ovf = ring_ovf;
                    pending_beats = {pending_beats, b};
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(t_opcode op, t_coord x, t_coord y);
        if (!calm && $urandom_range(99) < 6) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.opcode = op;
        in_ch.value_x = x;
        in_ch.value_y = y;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_beats(op, x, y);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending_beats.size() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver side: random back-pressure, none while calm.
    always @(negedge i_clk)
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);

    always @(posedge i_clk) begin
        t_row_beat w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat, row", out_ch.row_index, 0);
            end else begin
                w = pending_beats.pop_front();
                if (out_ch.inside_res !== w.in_poly)
                    report_mismatch("inside_res", out_ch.inside_res, w.in_poly);
                if (out_ch.row_index !== w.row)
                    report_mismatch("row_index", out_ch.row_index, w.row);
                if (out_ch.row_mask !== w.mask)
                    report_mismatch("row_mask", out_ch.row_mask, w.mask);
                if (out_ch.last !== w.last)
                    report_mismatch("last", out_ch.last, w.last);
                if (out_ch.vertex_overflow !== w.ovf)
                    report_mismatch("vertex_overflow", out_ch.vertex_overflow, w.ovf);
            end
        end
    end

    // Watchdog on cycles without any accepted beat on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_coord near_coord();
        return t_coord'(int'($urandom_range(40)) - 20);
    endfunction

    task automatic load_ring(longint xs[$], longint ys[$]);
        send_item(OP_CLEAR, 0, 0);
        foreach (xs[i])
            send_item(OP_APPEND, t_coord'(xs[i]), t_coord'(ys[i]));
    endtask

    task automatic test_empty_ring();
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_TEST, 0, 0);
        send_item(OP_TEST, 32'sh7fffffff, 32'sh80000000);
    endtask

    task automatic test_single_vertex();
        load_ring('{5}, '{-3});
        send_item(OP_TEST, 5, -3);
        send_item(OP_TEST, 6, -3);
    endtask

    // Square with a point on an edge, on a vertex, inside and outside, and a rasterize item.
    task automatic test_square_boundary();
        load_ring('{0, 10, 10, 0}, '{0, 0, 10, 10});
        send_item(OP_TEST, 5, 0);
        send_item(OP_TEST, 10, 10);
        send_item(OP_TEST, 5, 5);
        send_item(OP_TEST, 11, 5);
        send_item(OP_TEST, -1, 10);
        send_item(OP_RASTERIZE, 12, 12);
        wait_drained();
    endtask

    task automatic test_extreme_coords();
        load_ring('{longint'(32'sh80000000), 2147483647, 0},
                  '{longint'(32'sh80000000), longint'(32'sh80000000), 2147483647});
        send_item(OP_TEST, 0, 0);
        send_item(OP_TEST, 32'sh7fffffff, 32'sh7fffffff);
        send_item(OP_TEST, 32'sh80000000, 32'sh80000000);
        send_item(OP_RASTERIZE, 32'sh7fffffff, 32'sh7fffffff);
        send_item(OP_RASTERIZE, 32'sh80000000, 32'sh80000000);
        send_item(OP_RASTERIZE, 0, -40);
    endtask

    // Fills the ring past capacity, then checks the sticky flag and its clear.
    task automatic test_vertex_overflow();
        send_item(OP_CLEAR, 0, 0);
        for (int i = 0; i <= RING_DEPTH; i++)
            send_item(OP_APPEND, near_coord(), near_coord());
        send_item(OP_TEST, 0, 0);
        send_item(OP_RASTERIZE, 40, -40);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_TEST, 0, 0);
    endtask

    task automatic test_random_rings();
        int  n;
        bit  near;
        while (item_count < 500) begin
            calm = (item_count >= 250 && item_count < 350);
            near = ($urandom_range(3) != 0);
            send_item(OP_CLEAR, 0, 0);
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 70) : $urandom_range(0, 8);
            repeat (n)
                send_item(OP_APPEND, near ? near_coord() : t_coord'($urandom),
                          near ? near_coord() : t_coord'($urandom));
            repeat ($urandom_range(3, 10)) begin
                if (near && $urandom_range(1) == 0 && ring_len > 0)
                    send_item(OP_TEST, t_coord'(ring_x[$urandom_range(ring_len - 1)]),
                              near_coord());
                else
                    send_item(OP_TEST, near ? near_coord() : t_coord'($urandom),
                              near ? near_coord() : t_coord'($urandom));
            end
            if (n <= 8 && $urandom_range(5) == 0)
                send_item(OP_RASTERIZE,
                          near ? t_coord'(int'($urandom_range(128)) - 64) : t_coord'($urandom),
                          near ? t_coord'(int'($urandom_range(128)) - 64) : t_coord'($urandom));
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_CLEAR;
        in_ch.value_x = 0;
        in_ch.value_y = 0;
        item_count = 0;
        calm = 1'b0;
        ring_len = 0;
        ring_ovf = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_ring();
        test_single_vertex();
        test_square_boundary();
        test_extreme_coords();
        test_vertex_overflow();
        test_random_rings();

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
